/* design/ascii_command_line_parser_unit_assert.svh */
// Assertion macros shared by the checker of the command line parser.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASCII_COMMAND_LINE_PARSER_UNIT_ASSERT_SVH
`define ASCII_COMMAND_LINE_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ACLP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aclp assertion failed");

// Next-cycle implication, checked outside reset.
`define ACLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aclp assertion failed");

`endif

/* design/aclp_pkg.sv */
// Shared types and constants of the ASCII command line parser.
// No dependencies; every design module refers to it by scoped names.
package aclp_pkg;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_1 = 8'h31;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_L = 8'h6C;
    localparam logic [7:0] CH_LOWER_P = 8'h70;
    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    localparam logic [3:0] KIND_ADDR_SET  = 4'd0;
    localparam logic [3:0] KIND_MODE_SET  = 4'd1;
    localparam logic [3:0] KIND_MODE_BAD  = 4'd2;
    localparam logic [3:0] KIND_ECHO      = 4'd3;
    localparam logic [3:0] KIND_TX_HEADER = 4'd4;
    localparam logic [3:0] KIND_TX_BYTE   = 4'd5;
    localparam logic [3:0] KIND_FAIL_SRC  = 4'd6;
    localparam logic [3:0] KIND_FAIL_DST  = 4'd7;
    localparam logic [3:0] KIND_FAIL_COL  = 4'd8;
    localparam logic [3:0] KIND_FAIL_HEX  = 4'd9;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMD,
        S_LADDR1,
        S_LADDR2,
        S_PARG,
        S_TSKIP,
        S_TDST,
        S_TCOLON,
        S_THI,
        S_TLO,
        S_BHI,
        S_BLO
    } state_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_L,
        CMD_P,
        CMD_E,
        CMD_T
    } cmd_t;

    typedef struct packed {
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       is_space;
        logic       is_colon;
        logic       is_zero;
        logic       is_bit;
        logic       bit_val;
        cmd_t       cmd;
    } char_info_t;

    typedef struct packed {
        logic store;
        logic clear;
    } buf_ctl_t;

endpackage

/* design/aclp_char_class.sv */
// Shared character classifier: hex decode and the compares the parser needs.
// Depends on aclp_pkg.
module aclp_char_class (
    input  logic [7:0]             data,
    output aclp_pkg::char_info_t   info
);

    always_comb
    begin
        info          = '0;
        info.cmd      = aclp_pkg::CMD_NONE;
        info.is_space = (data == aclp_pkg::CH_SPACE);
        info.is_colon = (data == aclp_pkg::CH_COLON);
        info.is_zero  = (data == aclp_pkg::CH_NUL);
        info.is_bit   = (data == aclp_pkg::CH_DIGIT_0) || (data == aclp_pkg::CH_DIGIT_1);
        info.bit_val  = (data == aclp_pkg::CH_DIGIT_1);

        if (data >= aclp_pkg::CH_UPPER_A && data <= aclp_pkg::CH_UPPER_F)
        begin
            info.hex_ok  = 1'b1;
            info.hex_val = 4'(data - aclp_pkg::CH_UPPER_A) + 4'd10;
        end
        else if (data >= aclp_pkg::CH_LOWER_A && data <= aclp_pkg::CH_LOWER_F)
        begin
            info.hex_ok  = 1'b1;
            info.hex_val = 4'(data - aclp_pkg::CH_LOWER_A) + 4'd10;
        end
        else if (data >= aclp_pkg::CH_DIGIT_0 && data <= aclp_pkg::CH_DIGIT_9)
        begin
            info.hex_ok  = 1'b1;
            info.hex_val = 4'(data - aclp_pkg::CH_DIGIT_0);
        end

        // Setting the case bit folds exactly the upper and lower form of a letter.
        case (data | aclp_pkg::CASE_BIT)
            aclp_pkg::CH_LOWER_L: info.cmd = aclp_pkg::CMD_L;
            aclp_pkg::CH_LOWER_P: info.cmd = aclp_pkg::CMD_P;
            aclp_pkg::CH_LOWER_E: info.cmd = aclp_pkg::CMD_E;
            aclp_pkg::CH_LOWER_T: info.cmd = aclp_pkg::CMD_T;
            default:              info.cmd = aclp_pkg::CMD_NONE;
        endcase
    end

endmodule

/* design/aclp_line_buf.sv */
// Line memory with its fill count and a registered read port.
// Depends on aclp_pkg.
module aclp_line_buf #(
    parameter int LINE_CAPACITY = 96,
    localparam int LW    = $clog2(LINE_CAPACITY + 1),
    localparam int IW    = $clog2(LINE_CAPACITY),
    localparam int POS_W = LW + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  aclp_pkg::buf_ctl_t   ctl,
    input  logic [7:0]           wr_data,
    input  logic [POS_W-1:0]     rd_pos,
    output logic [LW-1:0]        len,
    output logic [7:0]           rd_data
);

    logic [7:0]    mem [LINE_CAPACITY];
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [7:0]    q_reg;
    logic          in_line_reg;

    always_comb
    begin
        len_next = len_reg;
        if (ctl.clear)
        begin
            len_next = '0;
        end
        else if (ctl.store)
        begin
            len_next = len_reg + LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.store)
        begin
            mem[len_reg[IW-1:0]] <= wr_data;
        end
        q_reg       <= mem[rd_pos[IW-1:0]];
        in_line_reg <= (rd_pos < {1'b0, len_reg});
    end

    // Positions at or past the line length read as zero.
    assign rd_data = in_line_reg ? q_reg : 8'h00;
    assign len     = len_reg;

endmodule

/* design/aclp_seq.sv */
// Parse sequencer: walks the stored line one position per cycle unless a held
// result stalls it, and drives the result register. Depends on aclp_pkg.
module aclp_seq #(
    parameter int LINE_CAPACITY     = 96,
    parameter int MAX_PAYLOAD_BYTES = 16,
    localparam int LW    = $clog2(LINE_CAPACITY + 1),
    localparam int POS_W = LW + 1,
    localparam int NW    = $clog2(MAX_PAYLOAD_BYTES + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    output logic                   char_ready,
    input  logic [7:0]             character,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [3:0]             result_kind,
    output logic [3:0]             address,
    output logic [3:0]             destination,
    output logic [4:0]             payload_length,
    output logic [7:0]             payload_byte,
    output logic                   report_all,
    output logic                   last,
    output aclp_pkg::buf_ctl_t     ctl,
    output logic [POS_W-1:0]       rd_pos,
    input  logic [LW-1:0]          len,
    input  aclp_pkg::char_info_t   info
);

    aclp_pkg::state_t state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] p0_reg, p0_next;
    logic [3:0]       src_reg, src_next;
    logic [3:0]       dst_reg, dst_next;
    logic [3:0]       hi_reg, hi_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [NW-1:0]    i_reg, i_next;
    logic             mode_reg, mode_next;

    logic             ov_reg, ov_next;
    logic [3:0]       kind_reg, addr_reg, dsto_reg;
    logic [4:0]       leno_reg;
    logic [7:0]       byte_reg;
    logic             ra_reg, last_reg;

    logic             out_free;
    logic             ordinary;
    logic             finish;
    logic             ld;
    logic [3:0]       ld_kind, ld_addr, ld_dst;
    logic [4:0]       ld_len;
    logic [7:0]       ld_byte;
    logic             ld_ra, ld_last;
    logic             payload_done;
    logic             byte_last;

    assign out_free     = !ov_reg || result_ready;
    assign ordinary     = (character != aclp_pkg::CH_NEWLINE)
                       && (character != aclp_pkg::CH_RETURN)
                       && (len < LW'(LINE_CAPACITY));
    assign payload_done = info.is_zero || (n_reg == NW'(MAX_PAYLOAD_BYTES));
    assign byte_last    = ((i_reg + NW'(1)) == n_reg);
    assign char_ready   = (state_reg == aclp_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        p0_next    = p0_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        hi_next    = hi_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        mode_next  = mode_reg;
        ctl        = '0;
        finish     = 1'b0;
        ld         = 1'b0;
        ld_kind    = aclp_pkg::KIND_ADDR_SET;
        ld_addr    = '0;
        ld_dst     = '0;
        ld_len     = '0;
        ld_byte    = '0;
        ld_ra      = mode_reg;
        ld_last    = 1'b1;

        case (state_reg)
            aclp_pkg::S_IDLE:
            begin
                if (char_valid)
                begin
                    if (ordinary)
                    begin
                        ctl.store = 1'b1;
                    end
                    else
                    begin
                        state_next = aclp_pkg::S_CMD;
                    end
                end
            end
            aclp_pkg::S_CMD:
            begin
                case (info.cmd)
                    aclp_pkg::CMD_L:
                    begin
                        pos_next   = POS_W'(1);
                        state_next = aclp_pkg::S_LADDR1;
                    end
                    aclp_pkg::CMD_P:
                    begin
                        pos_next   = POS_W'(1);
                        state_next = aclp_pkg::S_PARG;
                    end
                    aclp_pkg::CMD_E:
                    begin
                        if (out_free)
                        begin
                            ld      = 1'b1;
                            ld_kind = aclp_pkg::KIND_ECHO;
                            finish  = 1'b1;
                        end
                    end
                    aclp_pkg::CMD_T:
                    begin
                        pos_next   = POS_W'(1);
                        state_next = aclp_pkg::S_TSKIP;
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end
            aclp_pkg::S_LADDR1:
            begin
                if (info.hex_ok)
                begin
                    if (out_free)
                    begin
                        ld      = 1'b1;
                        ld_kind = aclp_pkg::KIND_ADDR_SET;
                        ld_addr = info.hex_val;
                        finish  = 1'b1;
                    end
                end
                else if (len > LW'(1))
                begin
                    pos_next   = POS_W'(2);
                    state_next = aclp_pkg::S_LADDR2;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            aclp_pkg::S_LADDR2:
            begin
                if (!info.hex_ok)
                begin
                    finish = 1'b1;
                end
                else if (out_free)
                begin
                    ld      = 1'b1;
                    ld_kind = aclp_pkg::KIND_ADDR_SET;
                    ld_addr = info.hex_val;
                    finish  = 1'b1;
                end
            end
            aclp_pkg::S_PARG:
            begin
                if (out_free)
                begin
                    ld     = 1'b1;
                    finish = 1'b1;
                    if (info.is_bit)
                    begin
                        mode_next = info.bit_val;
                        ld_kind   = aclp_pkg::KIND_MODE_SET;
                        ld_ra     = info.bit_val;
                    end
                    else
                    begin
                        ld_kind = aclp_pkg::KIND_MODE_BAD;
                    end
                end
            end
            aclp_pkg::S_TSKIP:
            begin
                if (info.is_space)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
                else if (info.hex_ok)
                begin
                    src_next   = info.hex_val;
                    pos_next   = pos_reg + POS_W'(1);
                    state_next = aclp_pkg::S_TDST;
                end
                else if (out_free)
                begin
                    ld      = 1'b1;
                    ld_kind = aclp_pkg::KIND_FAIL_SRC;
                    finish  = 1'b1;
                end
            end
            aclp_pkg::S_TDST:
            begin
                if (info.hex_ok)
                begin
                    dst_next   = info.hex_val;
                    pos_next   = pos_reg + POS_W'(1);
                    p0_next    = pos_reg + POS_W'(1);
                    n_next     = '0;
                    state_next = aclp_pkg::S_TCOLON;
                end
                else if (out_free)
                begin
                    ld      = 1'b1;
                    ld_kind = aclp_pkg::KIND_FAIL_DST;
                    finish  = 1'b1;
                end
            end
            aclp_pkg::S_TCOLON:
            begin
                if (payload_done)
                begin
                    // The payload checked out: send the header, then rescan the
                    // same positions to send the bytes.
                    if (out_free)
                    begin
                        ld      = 1'b1;
                        ld_kind = aclp_pkg::KIND_TX_HEADER;
                        ld_addr = src_reg;
                        ld_dst  = dst_reg;
                        ld_len  = 5'(n_reg);
                        ld_last = (n_reg == '0);
                        if (n_reg == '0)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            pos_next   = p0_reg + POS_W'(1);
                            i_next     = '0;
                            state_next = aclp_pkg::S_BHI;
                        end
                    end
                end
                else if (info.is_colon)
                begin
                    pos_next   = pos_reg + POS_W'(1);
                    state_next = aclp_pkg::S_THI;
                end
                else if (out_free)
                begin
                    ld      = 1'b1;
                    ld_kind = aclp_pkg::KIND_FAIL_COL;
                    finish  = 1'b1;
                end
            end
            aclp_pkg::S_THI:
            begin
                if (info.hex_ok)
                begin
                    pos_next   = pos_reg + POS_W'(1);
                    state_next = aclp_pkg::S_TLO;
                end
                else if (out_free)
                begin
                    ld      = 1'b1;
                    ld_kind = aclp_pkg::KIND_FAIL_HEX;
                    finish  = 1'b1;
                end
            end
            aclp_pkg::S_TLO:
            begin
                if (info.hex_ok)
                begin
                    n_next     = n_reg + NW'(1);
                    pos_next   = pos_reg + POS_W'(1);
                    state_next = aclp_pkg::S_TCOLON;
                end
                else if (out_free)
                begin
                    ld      = 1'b1;
                    ld_kind = aclp_pkg::KIND_FAIL_HEX;
                    finish  = 1'b1;
                end
            end
            aclp_pkg::S_BHI:
            begin
                hi_next    = info.hex_val;
                pos_next   = pos_reg + POS_W'(1);
                state_next = aclp_pkg::S_BLO;
            end
            aclp_pkg::S_BLO:
            begin
                if (out_free)
                begin
                    ld      = 1'b1;
                    ld_kind = aclp_pkg::KIND_TX_BYTE;
                    ld_addr = src_reg;
                    ld_dst  = dst_reg;
                    ld_len  = 5'(n_reg);
                    ld_byte = {hi_reg, info.hex_val};
                    ld_last = byte_last;
                    if (byte_last)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        i_next     = i_reg + NW'(1);
                        pos_next   = pos_reg + POS_W'(2);
                        state_next = aclp_pkg::S_BHI;
                    end
                end
            end
            default:
            begin
                finish = 1'b1;
            end
        endcase

        if (finish)
        begin
            ctl.clear  = 1'b1;
            pos_next   = '0;
            state_next = aclp_pkg::S_IDLE;
        end

        ov_next = ov_reg && !result_ready;
        if (ld)
        begin
            ov_next = 1'b1;
        end
    end

    // The memory reads at pos_next, so its registered data always belongs to pos_reg.
    assign rd_pos = pos_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aclp_pkg::S_IDLE;
            pos_reg   <= '0;
            mode_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            mode_reg  <= mode_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p0_reg  <= p0_next;
        src_reg <= src_next;
        dst_reg <= dst_next;
        hi_reg  <= hi_next;
        n_reg   <= n_next;
        i_reg   <= i_next;
        if (ld)
        begin
            kind_reg <= ld_kind;
            addr_reg <= ld_addr;
            dsto_reg <= ld_dst;
            leno_reg <= ld_len;
            byte_reg <= ld_byte;
            ra_reg   <= ld_ra;
            last_reg <= ld_last;
        end
    end

    assign result_valid   = ov_reg;
    assign result_kind    = kind_reg;
    assign address        = addr_reg;
    assign destination    = dsto_reg;
    assign payload_length = leno_reg;
    assign payload_byte   = byte_reg;
    assign report_all     = ra_reg;
    assign last           = last_reg;

endmodule

/* design/ascii_command_line_parser_unit.sv */
// Ordinary characters are stored and the block stays ready.
// A line end keeps it busy while the sequencer reads one position per cycle,
// unless a held result stalls it: for L and P it reads the argument positions,
// for E none; for T it scans the line and then rescans the payload bytes.
// Reset empties the line, clears the report-all mode and needs no clearing
// pass; line memory contents stay unknown.
module ascii_command_line_parser_unit #(
    parameter int LINE_CAPACITY     = 96,
    parameter int MAX_PAYLOAD_BYTES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  logic [7:0] character,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [3:0] result_kind,
    output logic [3:0] address,
    output logic [3:0] destination,
    output logic [4:0] payload_length,
    output logic [7:0] payload_byte,
    output logic       report_all,
    output logic       last
);

    localparam int LW    = $clog2(LINE_CAPACITY + 1);
    localparam int POS_W = LW + 1;

    aclp_pkg::buf_ctl_t   ctl;
    aclp_pkg::char_info_t info;
    logic [POS_W-1:0]     rd_pos;
    logic [LW-1:0]        len;
    logic [7:0]           rd_data;

    aclp_line_buf #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .wr_data (character),
        .rd_pos  (rd_pos),
        .len     (len),
        .rd_data (rd_data)
    );

    aclp_char_class u_char_class (
        .data (rd_data),
        .info (info)
    );

    aclp_seq #(
        .LINE_CAPACITY     (LINE_CAPACITY),
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (char_valid),
        .char_ready     (char_ready),
        .character      (character),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result_kind    (result_kind),
        .address        (address),
        .destination    (destination),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .report_all     (report_all),
        .last           (last),
        .ctl            (ctl),
        .rd_pos         (rd_pos),
        .len            (len),
        .info           (info)
    );

endmodule

/* design/aclp_checker.sv */
// Port-level checks of the command line parser, bound to the top level.
// Depends on aclp_pkg and ascii_command_line_parser_unit_assert.svh.
`include "ascii_command_line_parser_unit_assert.svh"

module aclp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       char_valid,
    input logic       char_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic [3:0] result_kind,
    input logic [3:0] address,
    input logic [3:0] destination,
    input logic [4:0] payload_length,
    input logic [7:0] payload_byte,
    input logic       report_all,
    input logic       last
);

    // A stalled result beat holds its contents.
    `ACLP_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable({result_kind, address, destination, payload_length, payload_byte, report_all, last}))

    `ACLP_ASSERT_NOW(a_kind_range, result_valid, result_kind <= aclp_pkg::KIND_FAIL_HEX)

    // Everything but a transmit header or byte is the only result of its line.
    `ACLP_ASSERT_NOW(a_single_last, result_valid && result_kind != aclp_pkg::KIND_TX_HEADER && result_kind != aclp_pkg::KIND_TX_BYTE, last)

    // Results are produced only while a line is being parsed.
    `ACLP_ASSERT_NOW(a_result_when_busy, $rose(result_valid), $past(!char_ready))

    // The block goes busy only after taking a character beat.
    `ACLP_ASSERT_NOW(a_busy_after_beat, $fell(char_ready), $past(char_valid))

endmodule

bind ascii_command_line_parser_unit aclp_checker u_aclp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .char_valid     (char_valid),
    .char_ready     (char_ready),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result_kind    (result_kind),
    .address        (address),
    .destination    (destination),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .report_all     (report_all),
    .last           (last)
);
